// File: hw/rtl/pfp_pkg.sv
// Shared types and constants for the ping frame parser.
// No dependencies; imported by every module of the block but the input register.
`default_nettype none

package pfp_pkg;

  localparam logic [3:0] PH_START1  = 4'd0;
  localparam logic [3:0] PH_START2  = 4'd1;
  localparam logic [3:0] PH_LEN_L   = 4'd2;
  localparam logic [3:0] PH_LEN_H   = 4'd3;
  localparam logic [3:0] PH_ID_L    = 4'd4;
  localparam logic [3:0] PH_ID_H    = 4'd5;
  localparam logic [3:0] PH_SRC     = 4'd6;
  localparam logic [3:0] PH_DST     = 4'd7;
  localparam logic [3:0] PH_PAYLOAD = 4'd8;
  localparam logic [3:0] PH_CHK_L   = 4'd9;
  localparam logic [3:0] PH_CHK_H   = 4'd10;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_GOOD = 2'd2;

  localparam logic [7:0] SYNC1_BYTE = 8'h42;  // 'B'
  localparam logic [7:0] SYNC2_BYTE = 8'h52;  // 'R'

  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] message_id;
    logic [15:0] frame_payload_len;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfp_in_stage.sv
// Input register of the ping frame parser: holds one received byte.
// Depends on nothing but the clock and reset.
`default_nettype none

module pfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  // The register refills in the same cycle that its byte moves on.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfp_parse.sv
// Frame parse state machine with running checksum and header capture.
// Depends on pfp_pkg for phase codes, status codes and the result type.
`default_nettype none

module pfp_parse
  import pfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [7:0]  byte_in,
  input  wire logic [15:0] max_len,
  output result_t          res
);

  logic [3:0]  phase, phase_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] length_held, length_held_next;
  logic [15:0] id_held, id_held_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  sum_low, sum_low_next;
  logic [15:0] sum_plus;
  logic [15:0] count_plus;
  logic [15:0] new_len;

  assign sum_plus   = running_sum + {8'd0, byte_in};
  assign count_plus = payload_count + 16'd1;
  assign new_len    = {byte_in, length_held[7:0]};

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    length_held_next   = length_held;
    id_held_next       = id_held;
    payload_count_next = payload_count;
    sum_low_next       = sum_low;
    res.status         = ST_BUSY;
    res.payload_valid  = 1'b0;
    res.payload_byte   = 8'd0;
    res.payload_index  = 16'd0;
    case (phase)
      PH_START1: begin
        if (byte_in == SYNC1_BYTE) begin
          running_sum_next = {8'd0, byte_in};
          phase_next       = PH_START2;
        end else begin
          res.status = ST_REJ;
        end
      end
      PH_START2: begin
        // A wrong second byte is dropped, not retried as a new start byte.
        if (byte_in == SYNC2_BYTE) begin
          running_sum_next = sum_plus;
          phase_next       = PH_LEN_L;
        end else begin
          phase_next = PH_START1;
          res.status = ST_REJ;
        end
      end
      PH_LEN_L: begin
        running_sum_next = sum_plus;
        length_held_next = {8'd0, byte_in};
        phase_next       = PH_LEN_H;
      end
      PH_LEN_H: begin
        running_sum_next = sum_plus;
        length_held_next = new_len;
        if (new_len > max_len) begin
          phase_next = PH_START1;
          res.status = ST_REJ;
        end else begin
          phase_next = PH_ID_L;
        end
      end
      PH_ID_L: begin
        running_sum_next = sum_plus;
        id_held_next     = {8'd0, byte_in};
        phase_next       = PH_ID_H;
      end
      PH_ID_H: begin
        running_sum_next = sum_plus;
        id_held_next     = {byte_in, id_held[7:0]};
        phase_next       = PH_SRC;
      end
      PH_SRC: begin
        running_sum_next = sum_plus;
        phase_next       = PH_DST;
      end
      PH_DST: begin
        running_sum_next   = sum_plus;
        payload_count_next = 16'd0;
        phase_next         = (length_held == 16'd0) ? PH_CHK_L : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next   = sum_plus;
        res.payload_valid  = 1'b1;
        res.payload_byte   = byte_in;
        res.payload_index  = payload_count;
        payload_count_next = count_plus;
        if (count_plus >= length_held) begin
          phase_next = PH_CHK_L;
        end
      end
      PH_CHK_L: begin
        sum_low_next = byte_in;
        phase_next   = PH_CHK_H;
      end
      PH_CHK_H: begin
        phase_next = PH_START1;
        res.status = ({byte_in, sum_low} == running_sum) ? ST_GOOD : ST_REJ;
      end
      default: begin
        phase_next = PH_START1;
        res.status = ST_REJ;
      end
    endcase
    res.message_id        = id_held_next;
    res.frame_payload_len = length_held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START1;
      running_sum   <= 16'd0;
      length_held   <= 16'd0;
      id_held       <= 16'd0;
      payload_count <= 16'd0;
      sum_low       <= 8'd0;
    end else if (advance) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      length_held   <= length_held_next;
      id_held       <= id_held_next;
      payload_count <= payload_count_next;
      sum_low       <= sum_low_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfp_out_stage.sv
// Result register of the ping frame parser.
// Depends on pfp_pkg for the result type.
`default_nettype none

module pfp_out_stage
  import pfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    held_valid,
  input  wire result_t res,
  output logic         advance,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_q
);

  // A new result loads whenever the register is empty or its transfer completes.
  assign advance = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ping_frame_parser_unit.sv
// Ping frame parser: one received byte in, one status result out per byte.
// Input transfers on in_valid/in_ready carry rx_byte; every byte yields exactly
// one result transfer on out_valid/out_ready with status, the payload byte and
// its index, and the current frame's message id and declared length.
// Frames are 'B' 'R', length (LE), id (LE), source, destination, payload,
// and a 16-bit LE checksum over every earlier byte of the frame.
// The limit on the declared length is written through cfg_valid/cfg_ready
// with cfg_data; it is always ready and should be written only while idle.
// The result of a byte passes the input register, then the parse logic, then
// the result register.
// Throughput: one byte per cycle while the receiver takes results, set by the parse step.
// Reset: the parser hunts for 'B', all held fields are zero, limit is 1024.
// When the receiver stalls the finished result holds and one more byte waits
// in the input register; in_ready then drops until the result is taken.
`default_nettype none

module ping_frame_parser_unit
  import pfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             payload_valid,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_index,
  output logic [15:0]      message_id,
  output logic [15:0]      frame_payload_len,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] max_payload_len;
  logic        held_valid;
  logic [7:0]  held_byte;
  logic        advance;
  result_t     res;
  result_t     res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_payload_len <= cfg_data;
    end
  end

  pfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (held_byte),
    .max_len (max_payload_len),
    .res     (res)
  );

  pfp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_q      (res_q)
  );

  assign status            = res_q.status;
  assign payload_valid     = res_q.payload_valid;
  assign payload_byte      = res_q.payload_byte;
  assign payload_index     = res_q.payload_index;
  assign message_id        = res_q.message_id;
  assign frame_payload_len = res_q.frame_payload_len;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ping_frame_parser_unit: drives framed byte streams
// and compares every status result against a cycle-free frame predictor.
// Depends on pfp_pkg for the phase, status and sync byte constants.

module tb_top
  import pfp_pkg::*;
();

  // Tracks the parser state for each accepted byte and holds the results it owes.
  class frame_scoreboard;
    logic [15:0] limit;
    logic [3:0]  phase;
    logic [15:0] sum;
    logic [15:0] len;
    logic [15:0] id;
    logic [15:0] count;
    logic [7:0]  chk_low;
    result_t     owed_q[$];
    int          errors;
    int          good_frames;
    int          rejects;
    int          payload_bytes;

    function new();
      limit = MAX_LEN_RESET;
      phase = PH_START1;
      sum = '0;
      len = '0;
      id = '0;
      count = '0;
      chk_low = '0;
      errors = 0;
      good_frames = 0;
      rejects = 0;
      payload_bytes = 0;
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction

    function void note_byte(input logic [7:0] b);
      result_t r;
      logic [15:0] rx_sum;
      r = '0;
      r.status = ST_BUSY;
      case (phase)
        PH_START1: begin
          if (b == SYNC1_BYTE) begin
            sum = {8'h00, b};
            phase = PH_START2;
          end else begin
            r.status = ST_REJ;
          end
        end
        PH_START2: begin
          // A failed second sync byte is dropped, even when it is itself a 'B'.
          if (b == SYNC2_BYTE) begin
            sum = sum + {8'h00, b};
            phase = PH_LEN_L;
          end else begin
            phase = PH_START1;
            r.status = ST_REJ;
          end
        end
        PH_LEN_L: begin
          sum = sum + {8'h00, b};
          len = {8'h00, b};
          phase = PH_LEN_H;
        end
        PH_LEN_H: begin
          sum = sum + {8'h00, b};
          len = {b, len[7:0]};
          if (len > limit) begin
            phase = PH_START1;
            r.status = ST_REJ;
          end else begin
            phase = PH_ID_L;
          end
        end
        PH_ID_L: begin
          sum = sum + {8'h00, b};
          id = {8'h00, b};
          phase = PH_ID_H;
        end
        PH_ID_H: begin
          sum = sum + {8'h00, b};
          id = {b, id[7:0]};
          phase = PH_SRC;
        end
        PH_SRC: begin
          sum = sum + {8'h00, b};
          phase = PH_DST;
        end
        PH_DST: begin
          sum = sum + {8'h00, b};
          count = '0;
          phase = (len == 16'd0) ? PH_CHK_L : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum = sum + {8'h00, b};
          r.payload_valid = 1'b1;
          r.payload_byte = b;
          r.payload_index = count;
          count = count + 16'd1;
          if (count >= len) begin
            phase = PH_CHK_L;
          end
        end
        PH_CHK_L: begin
          chk_low = b;
          phase = PH_CHK_H;
        end
        PH_CHK_H: begin
          rx_sum = {b, chk_low};
          phase = PH_START1;
          r.status = (rx_sum == sum) ? ST_GOOD : ST_REJ;
        end
        default: begin
          phase = PH_START1;
          r.status = ST_REJ;
        end
      endcase
      r.message_id = id;
      r.frame_payload_len = len;
      owed_q.push_back(r);
    endfunction

    task report(input string what, input int unsigned seen, input int unsigned want);
      errors++;
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, seen, want);
    endtask

    task check_result(input result_t seen);
      result_t want;
      if (owed_q.size() == 0) begin
        report("result with none owed, status", seen.status, 0);
        return;
      end
      want = owed_q.pop_front();
      if (seen.status != want.status)
        report("status", seen.status, want.status);
      if (seen.payload_valid != want.payload_valid)
        report("payload_valid", seen.payload_valid, want.payload_valid);
      if (seen.payload_byte != want.payload_byte)
        report("payload_byte", seen.payload_byte, want.payload_byte);
      if (seen.payload_index != want.payload_index)
        report("payload_index", seen.payload_index, want.payload_index);
      if (seen.message_id != want.message_id)
        report("message_id", seen.message_id, want.message_id);
      if (seen.frame_payload_len != want.frame_payload_len)
        report("frame_payload_len", seen.frame_payload_len, want.frame_payload_len);
      if (want.status == ST_GOOD) good_frames++;
      if (want.status == ST_REJ) rejects++;
      if (want.payload_valid) payload_bytes++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [15:0] message_id;
  logic [15:0] frame_payload_len;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  frame_scoreboard sb;
  int bytes_sent;
  bit no_idle;
  bit hold_request;
  int hold_left;

  ping_frame_parser_unit uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .payload_valid     (payload_valid),
    .payload_byte      (payload_byte),
    .payload_index     (payload_index),
    .message_id        (message_id),
    .frame_payload_len (frame_payload_len),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both transfer sides are observed at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready)
        sb.check_result({status, payload_valid, payload_byte, payload_index,
                         message_id, frame_payload_len});
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Entered and left just after a falling edge; valid stays high on return and drops only for random idles.
  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends a frame with a random id and payload; cut > 0 stops after that many bytes.
  task automatic send_frame(input logic [15:0] plen, input bit corrupt, input int cut);
    logic [7:0]  fb[$];
    logic [15:0] csum;
    logic [15:0] fid;
    int          n;
    int          i;
    fid = 16'($urandom_range(0, 65535));
    n = (cut > 0) ? cut : int'(plen) + 10;
    fb.push_back(SYNC1_BYTE);
    fb.push_back(SYNC2_BYTE);
    fb.push_back(plen[7:0]);
    fb.push_back(plen[15:8]);
    fb.push_back(fid[7:0]);
    fb.push_back(fid[15:8]);
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < int'(plen) && fb.size() < n; i++)
      fb.push_back(8'($urandom_range(0, 255)));
    csum = '0;
    foreach (fb[k]) csum = csum + {8'h00, fb[k]};
    if (corrupt) csum = csum ^ 16'($urandom_range(1, 65535));
    fb.push_back(csum[7:0]);
    fb.push_back(csum[15:8]);
    for (i = 0; i < n && i < fb.size(); i++) send_byte(fb[i]);
  endtask

  function automatic logic [15:0] pick_len(input logic [15:0] lim);
    int unsigned cap;
    if (lim <= 16'd300 && $urandom_range(0, 99) < 5) return lim;
    cap = (lim < 16'd12) ? lim : 12;
    if ($urandom_range(0, 99) < 3) cap = (lim < 16'd300) ? lim : 300;
    return 16'($urandom_range(0, cap));
  endfunction

  // Waits until every owed result has arrived, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed frames, with noise, broken starts, bad checksums, oversize and cut frames.
  task automatic run_random(input int quota, input bit pressure);
    int          first;
    int          r;
    int          plen;
    bit          pushed;
    logic [7:0]  b;
    first = bytes_sent;
    pushed = 1'b0;
    while (bytes_sent - first < quota) begin
      if (pressure && !pushed && bytes_sent - first > quota / 2) begin
        hold_request = 1'b1;
        pushed = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        do b = 8'($urandom_range(0, 255)); while (b == SYNC2_BYTE);
        send_byte(SYNC1_BYTE);
        send_byte(b);
      end else if (r < 18 && sb.limit != 16'hFFFF) begin
        send_frame(16'($urandom_range(int'(sb.limit) + 1, 65535)), 1'b0, 4);
      end else if (r < 25) begin
        plen = pick_len(sb.limit);
        send_frame(16'(plen), 1'b0, $urandom_range(1, plen + 9));
      end else begin
        send_frame(pick_len(sb.limit), r < 32, 0);
      end
    end
  endtask

  initial begin
    sb = new();
    bytes_sent = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: junk while hunting, a 'B' that fails as second sync byte,
    // a stray 'R', an empty good frame, a bad checksum and an oversize length.
    send_byte(8'hFF);
    send_byte(SYNC1_BYTE);
    send_byte(SYNC1_BYTE);
    send_byte(SYNC2_BYTE);
    send_frame(16'd0, 1'b0, 0);
    send_frame(16'd1, 1'b1, 0);
    send_frame(MAX_LEN_RESET + 16'd1, 1'b0, 4);

    run_random(500, 1'b0);
    write_limit(16'd0);
    run_random(250, 1'b0);
    write_limit(16'hFFFF);
    no_idle = 1'b1;
    run_random(350, 1'b0);
    no_idle = 1'b0;
    write_limit(16'd7);
    run_random(300, 1'b1);
    write_limit(16'($urandom_range(1, 400)));
    run_random(350, 1'b0);

    drain();
    repeat (4) @(negedge clk);
    if (sb.outstanding() != 0) sb.report("results never delivered", 0, sb.outstanding());
    $display("Sent %0d bytes under limits 1024, 0, 65535, 7 and a random one.",
             bytes_sent);
    $display("Saw %0d valid frames, %0d rejections, %0d streamed payload bytes.",
             sb.good_frames, sb.rejects, sb.payload_bytes);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_in_stage.sv
hw/rtl/pfp_parse.sv
hw/rtl/pfp_out_stage.sv
hw/rtl/ping_frame_parser_unit.sv
verif/tb_top.sv
